>>> hw/rtl/frl_pkg.sv
// ----------------------------------------------------------------------------
// Flow rate limiter package
// Shared types and constants for the TCP flow rate limiter.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int TICK_W        = 32;
  localparam int MS_SCALE      = 1000;
  localparam int SCALE_W       = 10;
  localparam int DIVD_W        = TICK_W + SCALE_W;
  localparam int DIV_CNT_W     = $clog2(DIVD_W);
  localparam int TPS_W         = 14;
  localparam int RATE_W        = 31;
  localparam int HALF_W        = DIVD_W / 2;
  localparam int PART_W        = HALF_W + RATE_W;
  localparam int ALLOW_W       = DIVD_W + RATE_W;

  localparam logic [20:0] THRESHOLD_RST = 21'd1048576;
  localparam logic [10:0] RATE_RST      = 11'd2000;
  localparam logic [9:0]  TPS_RST       = 10'd1000;

  typedef enum logic [1:0] {
    REG_BYTE_THRESHOLD   = 2'd0,
    REG_BYTES_PER_MS     = 2'd1,
    REG_TICKS_PER_SECOND = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0] byte_threshold;
    logic [RATE_W-1:0] bytes_per_ms;
    logic [TPS_W-1:0]  ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic              is_tcp;
    logic              fin;
    logic [15:0]       payload;
    logic [TICK_W-1:0] now;
  } meta_t;

  typedef struct packed {
    meta_t             meta;
    logic [SLOT_W-1:0] slot;
  } item_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] base;
    logic [31:0] last;
    logic [31:0] drop;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_DIV, ST_MUL, ST_CMP, ST_WRITE
  } back_state_t;

endpackage

>>> hw/rtl/frl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module frl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/frl_front.sv
// ----------------------------------------------------------------------------
// Flow rate limiter front end
// Accepts headers, works out the payload length and hashes the 4-tuple.
// ----------------------------------------------------------------------------
module frl_front import frl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        hold,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_tcp,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [15:0] total_length,
  input  logic [3:0]  ip_header_words,
  input  logic [3:0]  tcp_header_words,
  input  logic        fin_flag,
  input  logic [31:0] now_tick,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  // Only the low slot bits of each factor reach the slot index.
  logic              v1, v2, v3;
  meta_t             m1, m2, m3;
  logic [SLOT_W-1:0] f0, f1, f2, f3;
  logic [SLOT_W-1:0] f2b, f3b, f3c;
  logic [SLOT_W-1:0] p01, p012;
  logic [2*SLOT_W-1:0] prod01, prod012, prod_all;
  logic [6:0]        hdr;
  logic [16:0]       diff_len;
  meta_t             m_in;
  logic              adv;

  assign adv      = !(v3 && q_full);
  assign in_ready = adv && !hold;
  assign hdr      = {1'b0, ip_header_words, 2'b00} + {1'b0, tcp_header_words, 2'b00};
  assign diff_len = {1'b0, total_length} - {10'b0, hdr};

  always_comb begin
    m_in.is_tcp  = is_tcp;
    m_in.fin     = fin_flag;
    m_in.payload = diff_len[16] ? 16'd0 : diff_len[15:0];
    m_in.now     = now_tick;
  end

  assign prod01   = f0 * f1;
  assign prod012  = p01 * f2b;
  assign prod_all = p012 * f3c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && !hold;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0   <= src_addr[SLOT_W-1:0] + 1'b1;
      f1   <= dst_addr[SLOT_W-1:0] + 1'b1;
      f2   <= src_port[SLOT_W-1:0] + 1'b1;
      f3   <= dst_port[SLOT_W-1:0] + 1'b1;
      m1   <= m_in;
      p01  <= prod01[SLOT_W-1:0];
      f2b  <= f2;
      f3b  <= f3;
      m2   <= m1;
      p012 <= prod012[SLOT_W-1:0];
      f3c  <= f3b;
      m3   <= m2;
    end
  end

  assign q_push      = v3 && !q_full;
  assign q_item.meta = m3;
  assign q_item.slot = prod_all[SLOT_W-1:0];

endmodule

>>> hw/rtl/frl_queue.sv
// ----------------------------------------------------------------------------
// Flow rate limiter queue
// Two-entry queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module frl_queue import frl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("pop from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");

endmodule

>>> hw/rtl/frl_back.sv
// ----------------------------------------------------------------------------
// Flow rate limiter table engine
// Reads a TCP packet's flow slot, applies the threshold and rate check, writes it back.
// ----------------------------------------------------------------------------
module frl_back import frl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  item_t       q_head,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        verdict,
  output logic [11:0] flow_slot,
  output logic        flow_closed,
  output logic [31:0] accepted_bytes,
  output logic [31:0] dropped_bytes
);

  back_state_t state, state_next;
  logic [SLOT_W-1:0]    clr_addr;
  item_t                item;
  entry_t               ent, ram_rdata, ram_wdata;
  logic [31:0]          diff;
  logic [DIVD_W-1:0]    quo;
  logic [TPS_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PART_W-1:0]    plo, phi;
  logic                 drop_flag;
  logic                 ram_we, ram_re, load_out;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [TPS_W-1:0]     tps_eff;
  logic [TPS_W:0]       rem_sh;
  logic [31:0]          el, cur_diff, pay32;
  logic [ALLOW_W-1:0]   allow;
  logic                 under_thr;

  assign clearing  = state == ST_CLEAR;
  assign tps_eff   = (cfg.ticks_per_second == '0) ? TPS_W'(1) : cfg.ticks_per_second;
  assign rem_sh    = {rem, quo[DIVD_W-1]};
  assign el        = item.meta.now - ent.last;
  assign cur_diff  = ent.acc - ent.base;
  assign pay32     = {16'b0, item.meta.payload};
  assign under_thr = ent.acc < {1'b0, cfg.byte_threshold};
  assign allow     = {phi, HALF_W'(0)} + ALLOW_W'(plo);

  frl_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_head.slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = item.slot;
    ram_wdata  = ent;
    load_out   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == {SLOT_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          ram_re     = q_head.meta.is_tcp;
          state_next = q_head.meta.is_tcp ? ST_READ : ST_WRITE;
        end
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (item.meta.payload == '0 || under_thr || cfg.bytes_per_ms == '0) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == DIV_CNT_W'(DIVD_W - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_CMP;
      ST_CMP: state_next = ST_WRITE;
      ST_WRITE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          ram_we     = item.meta.is_tcp;
          if (item.meta.fin) begin
            ram_wdata      = '0;
            ram_wdata.last = item.meta.now;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item      <= q_head;
        drop_flag <= 1'b0;
        ent       <= '0;
      end
      ST_READ: ent <= ram_rdata;
      ST_EVAL: begin
        diff <= cur_diff;
        if (item.meta.payload != '0) begin
          if (under_thr) begin
            ent.acc  <= ent.acc + pay32;
            ent.base <= ent.base + pay32;
            ent.last <= item.meta.now;
          end else if (cfg.bytes_per_ms == '0) begin
            // No allowance at all: any unreported excess means a drop.
            if (cur_diff != '0) begin
              ent.drop  <= ent.drop + pay32;
              drop_flag <= 1'b1;
            end else begin
              ent.acc <= ent.acc + pay32;
            end
          end else begin
            quo <= {{SCALE_W{1'b0}}, el} * DIVD_W'(MS_SCALE);
            rem <= '0;
            cnt <= '0;
          end
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        cnt <= cnt + 1'b1;
        if (rem_sh >= {1'b0, tps_eff}) begin
          rem <= TPS_W'(rem_sh - {1'b0, tps_eff});
          quo <= {quo[DIVD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[TPS_W-1:0];
          quo <= {quo[DIVD_W-2:0], 1'b0};
        end
      end
      ST_MUL: begin
        plo <= quo[HALF_W-1:0] * cfg.bytes_per_ms;
        phi <= quo[DIVD_W-1:HALF_W] * cfg.bytes_per_ms;
      end
      ST_CMP: begin
        if (ALLOW_W'(diff) > allow) begin
          ent.drop  <= ent.drop + pay32;
          drop_flag <= 1'b1;
        end else begin
          ent.acc <= ent.acc + pay32;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      verdict        <= drop_flag;
      flow_slot      <= item.meta.is_tcp ? 12'(item.slot) : 12'd0;
      flow_closed    <= item.meta.is_tcp && item.meta.fin;
      accepted_bytes <= ent.acc;
      dropped_bytes  <= ent.drop;
    end
  end

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE && !q_empty)) else $error("pop outside idle");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt < DIV_CNT_W'(DIVD_W)) else $error("divider overran");
  a_non_tcp_clean: assert property (@(posedge clk) disable iff (rst)
    (load_out && !item.meta.is_tcp) |=> (!verdict && !flow_closed && flow_slot == 12'd0))
    else $error("non-TCP result not clean");
  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_WRITE)) else $error("stray table write");

endmodule

>>> hw/rtl/tcp_flow_rate_limiter.sv
// ----------------------------------------------------------------------------
// TCP flow rate limiter
// Per-flow policer giving one accept or drop verdict per packet header.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    is_tcp .. now_tick
// out       output     out_valid/out_ready  verdict .. dropped_bytes
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A header passes through the hash pipeline registers v1, v2 and v3 before it joins the queue.
// For a non-TCP packet the table engine goes from idle straight to write; below
// the threshold it reads, evaluates and writes; once the rate check runs it also
// divides elapsed ticks one bit per cycle, then multiplies and compares.
// After reset the table is cleared one slot a cycle, all 4096 slots, with in_ready low.
// Results wait in an output register; the engine stalls only when it is still full.
// ----------------------------------------------------------------------------
module tcp_flow_rate_limiter import frl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_tcp,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [15:0] total_length,
  input  logic [3:0]  ip_header_words,
  input  logic [3:0]  tcp_header_words,
  input  logic        fin_flag,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        verdict,
  output logic [11:0] flow_slot,
  output logic        flow_closed,
  output logic [31:0] accepted_bytes,
  output logic [31:0] dropped_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  logic  clearing, q_full, q_empty, q_push, q_pop;
  item_t q_item, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.byte_threshold   <= RATE_W'(THRESHOLD_RST);
      cfg.bytes_per_ms     <= RATE_W'(RATE_RST);
      cfg.ticks_per_second <= TPS_W'(TPS_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BYTE_THRESHOLD:   cfg.byte_threshold   <= cfg_data[RATE_W-1:0];
        REG_BYTES_PER_MS:     cfg.bytes_per_ms     <= cfg_data[RATE_W-1:0];
        REG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_data[TPS_W-1:0];
        default: ;
      endcase
    end
  end

  frl_front u_front (
    .clk              (clk),
    .rst              (rst),
    .hold             (clearing),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .is_tcp           (is_tcp),
    .src_addr         (src_addr),
    .dst_addr         (dst_addr),
    .src_port         (src_port),
    .dst_port         (dst_port),
    .total_length     (total_length),
    .ip_header_words  (ip_header_words),
    .tcp_header_words (tcp_header_words),
    .fin_flag         (fin_flag),
    .now_tick         (now_tick),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_item)
  );

  frl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  frl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .flow_slot      (flow_slot),
    .flow_closed    (flow_closed),
    .accepted_bytes (accepted_bytes),
    .dropped_bytes  (dropped_bytes)
  );

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// TCP flow rate limiter testbench
// Drives packet header summaries through the limiter, predicts each verdict
// and the flow slot totals with a local copy of the flow table, and checks
// every result transaction in order. Configuration changes between phases.
// ----------------------------------------------------------------------------
module tb_top import frl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 4096;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        is_tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] total_length;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic        fin_flag;
    logic [31:0] now_tick;
  } pkt_t;

  localparam int PKT_W = $bits(pkt_t);

  typedef struct packed {
    logic        verdict;
    logic [11:0] flow_slot;
    logic        flow_closed;
    logic [31:0] accepted_bytes;
    logic [31:0] dropped_bytes;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  pkt_t pkt_drv = '0;
  logic out_valid, out_ready = 1'b0;
  verdict_t res;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  tcp_flow_rate_limiter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .is_tcp(pkt_drv.is_tcp), .src_addr(pkt_drv.src_addr), .dst_addr(pkt_drv.dst_addr),
    .src_port(pkt_drv.src_port), .dst_port(pkt_drv.dst_port),
    .total_length(pkt_drv.total_length), .ip_header_words(pkt_drv.ip_header_words),
    .tcp_header_words(pkt_drv.tcp_header_words), .fin_flag(pkt_drv.fin_flag),
    .now_tick(pkt_drv.now_tick),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(res.verdict), .flow_slot(res.flow_slot), .flow_closed(res.flow_closed),
    .accepted_bytes(res.accepted_bytes), .dropped_bytes(res.dropped_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: the flow table and configuration as the limiter holds them.
  logic [31:0] tbl_sa [NSLOT];
  logic [31:0] tbl_da [NSLOT];
  logic [31:0] tbl_ports [NSLOT];
  logic [31:0] tbl_acc [NSLOT];
  logic [31:0] tbl_base [NSLOT];
  logic [31:0] tbl_last [NSLOT];
  logic [31:0] tbl_drop [NSLOT];
  logic [30:0] threshold_q;
  logic [30:0] rate_q;
  logic [13:0] tps_q;

  pkt_t     pending_pkts[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;
  longint   cycles = 0;
  bit       quiet_out = 1'b0;     // stretch with no receiver idling
  bit       quiet_in = 1'b0;
  bit       hold_req = 1'b0;      // long receiver hold-off requested
  logic     in_ready_seen = 1'b0;

  function automatic logic [11:0] flow_hash(pkt_t p);
    logic [63:0] h;
    h = {52'd0, p.src_addr[11:0]} + 64'd1;
    h = (h * ({52'd0, p.dst_addr[11:0]} + 64'd1)) & 64'hFFFF_FFFF;
    h = (h * ({52'd0, p.src_port[11:0]} + 64'd1)) & 64'hFFFF_FFFF;
    h = (h * ({52'd0, p.dst_port[11:0]} + 64'd1)) & 64'hFFFF_FFFF;
    return h[11:0];
  endfunction

  function automatic verdict_t police(pkt_t p);
    verdict_t r;
    logic [11:0] s;
    logic [16:0] hdr;
    logic [31:0] payload;
    logic [63:0] tps, el, ms, diff, allow;
    logic [127:0] prod;
    r = '0;
    if (!p.is_tcp) return r;
    s = flow_hash(p);
    if (tbl_sa[s] == 0 && tbl_da[s] == 0 && tbl_ports[s] == 0) begin
      tbl_sa[s] = p.src_addr;
      tbl_da[s] = p.dst_addr;
      tbl_ports[s] = {p.src_port, p.dst_port};
    end
    hdr = {p.ip_header_words, 2'b00} + {p.tcp_header_words, 2'b00};
    payload = ({1'b0, p.total_length} > hdr) ? 32'(p.total_length - hdr) : 32'd0;
    if (payload != 0) begin
      if ({1'b0, tbl_acc[s]} < {2'b0, threshold_q}) begin
        tbl_acc[s] += payload;
        tbl_base[s] += payload;
        tbl_last[s] = p.now_tick;
      end else begin
        tps = (tps_q == 0) ? 64'd1 : 64'(tps_q);
        el = 64'(32'(p.now_tick - tbl_last[s]));
        ms = (el * 64'd1000) / tps;
        diff = 64'(32'(tbl_acc[s] - tbl_base[s]));
        prod = 128'(ms) * 128'(rate_q);
        allow = (prod[127:64] != 0) ? '1 : prod[63:0];
        if (diff > allow) begin
          tbl_drop[s] += payload;
          r.verdict = 1'b1;
        end else begin
          tbl_acc[s] += payload;
        end
      end
    end
    r.flow_slot = s;
    r.flow_closed = p.fin_flag;
    r.accepted_bytes = tbl_acc[s];
    r.dropped_bytes = tbl_drop[s];
    if (p.fin_flag) begin
      tbl_sa[s] = 0; tbl_da[s] = 0; tbl_ports[s] = 0;
      tbl_acc[s] = 0; tbl_base[s] = 0; tbl_drop[s] = 0;
      tbl_last[s] = p.now_tick;
    end
    return r;
  endfunction

  // Driver: inputs change on the falling edge, after the rising-edge handshake.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_pkts.size() != 0 && (quiet_in || $urandom_range(99) >= 35)) begin
          pkt_drv <= pending_pkts.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_req) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_out || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_ready_seen <= in_valid && in_ready;
    if (in_valid && in_ready) expected_verdicts.push_back(police(pkt_drv));
    if (out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res);
        errors++;
      end else begin
        verdict_t e;
        e = expected_verdicts.pop_front();
        if (e !== res) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, res);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BYTE_THRESHOLD: threshold_q = val[30:0];
      REG_BYTES_PER_MS:   rate_q = val[30:0];
      default:            tps_q = val[13:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pkts.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Random TCP packet confined to a few flows so that slots fill and police.
  function automatic pkt_t flow_pkt(int flow, logic [31:0] t);
    pkt_t p;
    p.is_tcp = 1'b1;
    p.src_addr = 32'h0A00_0000 + flow;
    p.dst_addr = 32'hC0A8_0001 + flow * 7;
    p.src_port = 16'(1024 + flow);
    p.dst_port = 16'd80;
    p.ip_header_words = 4'd5;
    p.tcp_header_words = 4'd5;
    p.total_length = 16'($urandom_range(1500, 40));
    p.fin_flag = ($urandom_range(99) < 3);
    p.now_tick = t;
    return p;
  endfunction

  function automatic pkt_t noise_pkt();
    pkt_t p;
    p = PKT_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    p.fin_flag = ($urandom_range(9) == 0);
    return p;
  endfunction

  task automatic run_phase(int n);
    logic [31:0] t;
    t = $urandom;
    for (int i = 0; i < n; i++) begin
      t += $urandom_range(3);
      if ($urandom_range(99) < 75) pending_pkts.push_back(flow_pkt($urandom_range(5), t));
      else pending_pkts.push_back(noise_pkt());
    end
    drain();
  endtask

  initial begin
    pkt_t p;
    threshold_q = 31'd1048576;
    rate_q = 31'd2000;
    tps_q = 14'd1000;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_sa[i] = 0; tbl_da[i] = 0; tbl_ports[i] = 0; tbl_acc[i] = 0;
      tbl_base[i] = 0; tbl_last[i] = 0; tbl_drop[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, non-TCP, underflow, zero payload, FIN, wrap of time.
    p = '1; pending_pkts.push_back(p);
    p = '0; p.is_tcp = 1'b1; pending_pkts.push_back(p);
    p = '1; p.is_tcp = 1'b0; pending_pkts.push_back(p);
    p = '1; p.fin_flag = 1'b0; p.total_length = 16'd100; pending_pkts.push_back(p);
    p.total_length = 16'd120; p.ip_header_words = 4'd15; p.tcp_header_words = 4'd15;
    pending_pkts.push_back(p);
    p.total_length = 16'hFFFF; p.ip_header_words = 4'd0; p.tcp_header_words = 4'd0;
    p.now_tick = 32'hFFFF_FFF0; pending_pkts.push_back(p);
    p.now_tick = 32'd5; p.fin_flag = 1'b1; pending_pkts.push_back(p);
    p = flow_pkt(9, 32'd0); p.fin_flag = 1'b0; p.total_length = 16'd40;
    pending_pkts.push_back(p);
    p.fin_flag = 1'b1; pending_pkts.push_back(p);
    drain();

    // Small threshold so that policing begins quickly; receiver stalls hard.
    write_reg(REG_BYTE_THRESHOLD, 32'd3000);
    write_reg(REG_BYTES_PER_MS, 32'd1);
    write_reg(REG_TICKS_PER_SECOND, 32'd1);
    hold_req = 1'b1;
    fork
      run_phase(200);
      begin
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
    join

    write_reg(REG_BYTE_THRESHOLD, 32'd0);
    write_reg(REG_BYTES_PER_MS, 32'h7FFF_FFFF);
    write_reg(REG_TICKS_PER_SECOND, 32'd10000);
    quiet_in = 1'b1; quiet_out = 1'b1;
    run_phase(150);
    quiet_in = 1'b0; quiet_out = 1'b0;

    write_reg(REG_BYTE_THRESHOLD, 32'h7FFF_FFFF);
    write_reg(REG_BYTES_PER_MS, 32'd0);
    run_phase(150);

    write_reg(REG_BYTE_THRESHOLD, 32'd2000);
    write_reg(REG_BYTES_PER_MS, 32'd50);
    write_reg(REG_TICKS_PER_SECOND, 32'd1000);
    run_phase(300);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
